[rtl/urs_pkg.sv]
// Ultrasonic range scanner package: phase codes, register indexes, sizing
// constants and the structs shared by the ranging core and the top level.
// No dependencies.
package urs_pkg;

	localparam int NUM_SENSORS_DEF = 4;
	localparam int COUNT_BITS_DEF  = 16;

	localparam int DIST_W   = 10;
	localparam int SAFE_W   = 10;
	localparam int TMO_W    = 16;
	localparam int TRIG_W   = 8;
	localparam int CFG_W    = 16;
	localparam int LANES    = 4;
	localparam int SENS_W   = 2;

	// distance = ticks * 34300 / 2000000 = ticks * 343 / 20000
	localparam int REM_W    = 15;
	localparam logic [REM_W-1:0]  DIST_NUM = REM_W'(343);
	localparam logic [REM_W-1:0]  DIST_DEN = REM_W'(20000);
	localparam logic [DIST_W-1:0] DIST_MAX = '1;

	localparam logic [SAFE_W-1:0] SAFE_RST = SAFE_W'(30);
	localparam logic [TMO_W-1:0]  TMO_RST  = TMO_W'(30000);
	localparam logic [TRIG_W-1:0] TRIG_RST = TRIG_W'(10);

	typedef enum logic [1:0] {
		CFG_OBST_LIMIT    = 2'd0,
		CFG_ECHO_TIMEOUT  = 2'd1,
		CFG_TRIGGER_LEN   = 2'd2
	} cfg_idx_t;

	typedef enum logic [3:0] {
		PH_IDLE = 4'b0001,
		PH_TRIG = 4'b0010,
		PH_WAIT = 4'b0100,
		PH_HIGH = 4'b1000
	} phase_t;

	typedef struct packed {
		logic [SAFE_W-1:0] obst_limit;
		logic [TMO_W-1:0]  echo_timeout;
		logic [TRIG_W-1:0] trigger_len;
	} cfg_t;

	typedef struct packed {
		logic [LANES-1:0]  trigger_out;
		logic              busy_res;
		logic              distance_valid;
		logic [SENS_W-1:0] sensor_index;
		logic [DIST_W-1:0] distance_cm;
		logic              timed_out;
		logic [LANES-1:0]  obstacle_flags;
		logic              round_done;
	} result_t;

endpackage

[rtl/urs_ranger.sv]
// Ranging core: trigger/echo sequencer over the sensors, pulse timer with a
// running centimeter count, and obstacle flags. Result is combinational.
// Depends on urs_pkg.
module urs_ranger import urs_pkg::*; #(
	parameter int NUM_SENSORS = NUM_SENSORS_DEF,
	parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic             start_round,
	input  logic [LANES-1:0] echo_levels,
	input  cfg_t             cfg,
	output result_t          res
);

	localparam int CMP_W = (COUNT_BITS > TMO_W) ? COUNT_BITS : TMO_W;
	localparam logic [SENS_W:0]       SENS_CNT = (SENS_W+1)'(NUM_SENSORS);
	localparam logic [COUNT_BITS-1:0] TICK_MAX = '1;

	phase_t                  phase_q, phase_n;
	logic [SENS_W-1:0]       sensor_q, sensor_n;
	logic [COUNT_BITS-1:0]   tick_q, tick_n, tick_inc;
	logic [LANES-1:0]        obst_q, obst_n;
	logic [DIST_W-1:0]       dist_q, dist_n;
	logic [REM_W-1:0]        rem_q, rem_n, rem_sum;
	logic                    echo, limit, finish, tmo, done, last;
	logic [LANES-1:0]        sbit, trig;
	logic [DIST_W-1:0]       dist_out;

	always_comb begin
		echo     = echo_levels[sensor_q];
		sbit     = LANES'(1) << sensor_q;
		limit    = (CMP_W'(tick_q) >= CMP_W'(cfg.echo_timeout)) || (tick_q == TICK_MAX);
		tick_inc = (tick_q != TICK_MAX) ? tick_q + 1'b1 : tick_q;
		rem_sum  = rem_q + DIST_NUM;
		last     = !(({1'b0, sensor_q} + 1'b1) < SENS_CNT);

		phase_n  = phase_q;
		sensor_n = sensor_q;
		tick_n   = tick_q;
		obst_n   = obst_q;
		dist_n   = dist_q;
		rem_n    = rem_q;
		trig     = '0;
		finish   = 1'b0;
		tmo      = 1'b0;
		done     = 1'b0;
		dist_out = '0;

		case (phase_q)
			PH_IDLE: begin
				if (start_round) begin
					phase_n  = PH_TRIG;
					sensor_n = '0;
					tick_n   = '0;
				end
			end
			PH_TRIG: begin
				trig   = sbit;
				tick_n = tick_inc;
				if (COUNT_BITS'(cfg.trigger_len) <= tick_inc) begin
					phase_n = PH_WAIT;
					tick_n  = '0;
				end
			end
			PH_WAIT: begin
				if (echo) begin
					phase_n = PH_HIGH;
					tick_n  = COUNT_BITS'(1);
					dist_n  = '0;
					rem_n   = DIST_NUM;
				end else if (limit) begin
					finish = 1'b1;
					tmo    = 1'b1;
				end else begin
					tick_n = tick_q + 1'b1;
				end
			end
			PH_HIGH: begin
				if (!echo) begin
					finish   = 1'b1;
					dist_out = dist_q;
				end else if (limit) begin
					finish = 1'b1;
					tmo    = 1'b1;
				end else begin
					tick_n = tick_q + 1'b1;
					if (rem_sum >= DIST_DEN) begin
						rem_n  = rem_sum - DIST_DEN;
						dist_n = (dist_q != DIST_MAX) ? dist_q + 1'b1 : dist_q;
					end else begin
						rem_n  = rem_sum;
					end
				end
			end
			default: begin
				phase_n = PH_IDLE;
			end
		endcase

		if (finish) begin
			if (tmo) begin
				dist_out = (cfg.obst_limit != DIST_MAX) ? cfg.obst_limit + 1'b1 : DIST_MAX;
			end
			if (dist_out < cfg.obst_limit) begin
				obst_n = obst_q | sbit;
			end else begin
				obst_n = obst_q & ~sbit;
			end
			tick_n = '0;
			if (!last) begin
				sensor_n = sensor_q + 1'b1;
				phase_n  = PH_TRIG;
			end else begin
				sensor_n = '0;
				phase_n  = PH_IDLE;
				done     = 1'b1;
			end
		end

		res.trigger_out    = trig;
		res.busy_res       = (phase_n != PH_IDLE);
		res.distance_valid = finish;
		res.sensor_index   = finish ? sensor_q : '0;
		res.distance_cm    = dist_out;
		res.timed_out      = tmo;
		res.obstacle_flags = obst_n;
		res.round_done     = done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			sensor_q <= '0;
			tick_q   <= '0;
			obst_q   <= '0;
			dist_q   <= '0;
			rem_q    <= '0;
		end else if (step) begin
			phase_q  <= phase_n;
			sensor_q <= sensor_n;
			tick_q   <= tick_n;
			obst_q   <= obst_n;
			dist_q   <= dist_n;
			rem_q    <= rem_n;
		end
	end

endmodule

[rtl/ultrasonic_range_scanner.sv]
// Ultrasonic range scanner top level: configuration registers, ranging core
// and the registered result stage. Depends on urs_pkg and urs_ranger.
//
// Usage: every transfer on the s_ channel is one microsecond tick carrying
// a start request and the four echo levels. Every accepted tick yields
// exactly one result transfer on the m_ channel: trigger drive, busy,
// completion of a sensor measurement (m_tuser) with its index, distance
// and timeout mark, the obstacle flags, and end of round on m_tlast.
// Each accepted tick's result is registered in the result register.
// Throughput is one tick per cycle while s_tready is high;
// the per-tick update is a single pass from the state registers through
// the sequencer, pulse timer and centimeter counter.
// When m_tready is low, the result register holds and s_tready drops
// only while that result is still waiting; a tick is taken in the same
// cycle the waiting result leaves. Reset puts the sequencer in idle,
// clears obstacle flags and counters, empties the result register and
// loads the default thresholds (30 cm, 30000 ticks, 10 tick trigger).
// Write configuration on cfg_we only while no round is in progress.
module ultrasonic_range_scanner import urs_pkg::*; #(
	parameter int NUM_SENSORS = NUM_SENSORS_DEF,
	parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [CFG_W-1:0] cfg_wdata,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [7:0]       s_tdata,  // start_round, echo_levels[3:0]
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [23:0]      m_tdata,  // trigger_out[3:0], busy_res, sensor_index[1:0],
	                                   // distance_cm[9:0], timed_out, obstacle_flags[3:0]
	output logic             m_tuser,  // distance_valid
	output logic             m_tlast   // round_done
);

	cfg_t    cfg_q;
	result_t res, res_q;
	logic    out_valid_q;
	logic    step;

	assign s_tready = !out_valid_q || m_tready;
	assign step     = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.obst_limit    <= SAFE_RST;
			cfg_q.echo_timeout  <= TMO_RST;
			cfg_q.trigger_len   <= TRIG_RST;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_OBST_LIMIT:    cfg_q.obst_limit    <= cfg_wdata[SAFE_W-1:0];
				CFG_ECHO_TIMEOUT:  cfg_q.echo_timeout  <= cfg_wdata[TMO_W-1:0];
				CFG_TRIGGER_LEN:   cfg_q.trigger_len   <= cfg_wdata[TRIG_W-1:0];
				default: ;
			endcase
		end
	end

	urs_ranger #(
		.NUM_SENSORS (NUM_SENSORS),
		.COUNT_BITS  (COUNT_BITS)
	) u_ranger (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.start_round (s_tdata[0]),
		.echo_levels (s_tdata[4:1]),
		.cfg         (cfg_q),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = res_q.distance_valid;
	assign m_tlast  = res_q.round_done;
	assign m_tdata  = {2'b00, res_q.obstacle_flags, res_q.timed_out, res_q.distance_cm,
		res_q.sensor_index, res_q.busy_res, res_q.trigger_out};

endmodule

[rtl/urs_checker.sv]
// Port-level checks for the ultrasonic range scanner, bound to the top level.
// Depends on urs_pkg and ultrasonic_range_scanner.
module urs_checker import urs_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             m_tvalid,
	input logic             m_tready,
	input logic [23:0]      m_tdata,
	input logic             m_tuser,
	input logic             m_tlast
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
		&& $stable(m_tlast))
		else $error("stalled result changed");

	a_done_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tuser && !m_tdata[4])
		else $error("round end without completed measurement or still busy");

	a_trig_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> $onehot0(m_tdata[3:0]))
		else $error("more than one trigger driven");

	a_trig_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[3:0] != 4'd0) |-> m_tdata[4] && !m_tuser)
		else $error("trigger driven outside a round");

	a_idle_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> (m_tdata[17:5] == 13'd0) && !m_tlast)
		else $error("measurement fields set without completion");

endmodule

bind ultrasonic_range_scanner urs_checker u_urs_checker (.*);
